[rtl/pph_pkg.sv]
package pph_pkg;

  localparam int unsigned STAMP_BITS  = 32;
  localparam int unsigned INDEX_BITS  = 7;
  localparam int unsigned LIMIT_BITS  = 14;
  localparam int unsigned TARGET_BITS = 10;
  localparam int unsigned OUT_COUNT_BITS = 10;
  localparam int unsigned CFG_DATA_BITS = 14;

  localparam logic [LIMIT_BITS-1:0]  LOWER_LIMIT_RESET   = 14'd950;
  localparam logic [TARGET_BITS-1:0] PERIOD_TARGET_RESET = 10'd1000;

  typedef enum logic [1:0] {
    KIND_CAPTURE = 2'd0,
    KIND_READ    = 2'd1,
    KIND_START   = 2'd2
  } kind_t;

  typedef enum logic {
    REG_LOWER_LIMIT   = 1'b0,
    REG_PERIOD_TARGET = 1'b1
  } reg_index_t;

  // what a transaction asks of the bin cells
  typedef struct packed {
    logic inc;
    logic rd;
  } cmd_t;

  // result fields that ride along the chain unchanged
  typedef struct packed {
    logic [STAMP_BITS-1:0] period;
    logic                  in_window;
    logic                  run_done;
  } res_t;

endpackage

[rtl/pph_front.sv]
module pph_front import pph_pkg::*; #(
  parameter int unsigned BIN_COUNT = 101,
  parameter int unsigned BIN_W     = 7
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                    in_valid,
  input  logic                    advance,
  output logic                    in_ready,
  input  logic [1:0]              kind,
  input  logic [STAMP_BITS-1:0]   timestamp,
  input  logic [INDEX_BITS-1:0]   bin_index,
  output logic                    op_valid,
  output cmd_t                    op_cmd,
  output logic [BIN_W-1:0]        op_bin,
  output res_t                    op_res
);

  localparam logic [STAMP_BITS-1:0] LAST_BIN = STAMP_BITS'(BIN_COUNT - 1);
  localparam logic [STAMP_BITS-1:0] BIN_TOTAL = STAMP_BITS'(BIN_COUNT);

  logic [LIMIT_BITS-1:0]  lower_limit_r;
  logic [TARGET_BITS-1:0] period_target_r;
  logic [STAMP_BITS-1:0]  prev_edge_r, prev_edge_nxt;
  logic                   have_ref_r, have_ref_nxt;
  logic [TARGET_BITS-1:0] taken_r, taken_nxt;
  logic                   armed_r, armed_nxt;

  logic                   op_valid_r;
  cmd_t                   op_cmd_r, cmd_nxt;
  logic [BIN_W-1:0]       op_bin_r, bin_nxt;
  res_t                   op_res_r, res_nxt;

  logic                   accept;
  logic                   reached;
  logic [STAMP_BITS-1:0]  period;
  logic [STAMP_BITS:0]    offset;
  logic                   window;
  logic [STAMP_BITS-1:0]  idx_ext;

  assign in_ready = advance || !op_valid_r;
  assign accept   = in_valid && in_ready;
  assign reached  = armed_r && (taken_r >= period_target_r);

  assign period  = timestamp - prev_edge_r;
  assign offset  = {1'b0, period} - {{(STAMP_BITS + 1 - LIMIT_BITS){1'b0}}, lower_limit_r};
  assign window  = !offset[STAMP_BITS] && (offset[STAMP_BITS-1:0] <= LAST_BIN);
  assign idx_ext = STAMP_BITS'(bin_index);

  always_comb begin
    prev_edge_nxt = prev_edge_r;
    have_ref_nxt  = have_ref_r;
    taken_nxt     = taken_r;
    armed_nxt     = armed_r;
    cmd_nxt       = '0;
    bin_nxt       = '0;
    res_nxt       = '0;
    case (kind)
      KIND_CAPTURE: begin
        if (armed_r && !reached) begin
          prev_edge_nxt = timestamp;
          if (!have_ref_r) begin
            have_ref_nxt = 1'b1;
          end else begin
            taken_nxt         = taken_r + 1'b1;
            res_nxt.period    = period;
            res_nxt.in_window = window;
            cmd_nxt.inc       = window;
            bin_nxt           = offset[BIN_W-1:0];
          end
        end
      end
      KIND_READ: begin
        if (idx_ext < BIN_TOTAL) begin
          cmd_nxt.rd = 1'b1;
          bin_nxt    = idx_ext[BIN_W-1:0];
        end
      end
      KIND_START: begin
        have_ref_nxt = 1'b0;
        taken_nxt    = '0;
        armed_nxt    = 1'b1;
      end
      default: begin
      end
    endcase
    res_nxt.run_done = armed_nxt && (taken_nxt >= period_target_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_limit_r   <= LOWER_LIMIT_RESET;
      period_target_r <= PERIOD_TARGET_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOWER_LIMIT:   lower_limit_r   <= cfg_wdata[LIMIT_BITS-1:0];
        REG_PERIOD_TARGET: period_target_r <= cfg_wdata[TARGET_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_edge_r <= '0;
      have_ref_r  <= 1'b0;
      taken_r     <= '0;
      armed_r     <= 1'b0;
      op_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        prev_edge_r <= prev_edge_nxt;
        have_ref_r  <= have_ref_nxt;
        taken_r     <= taken_nxt;
        armed_r     <= armed_nxt;
      end
      if (in_ready) begin
        op_valid_r <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_cmd_r <= cmd_nxt;
      op_bin_r <= bin_nxt;
      op_res_r <= res_nxt;
    end
  end

  assign op_valid = op_valid_r;
  assign op_cmd   = op_cmd_r;
  assign op_bin   = op_bin_r;
  assign op_res   = op_res_r;

endmodule

[rtl/pph_cell.sv]
module pph_cell import pph_pkg::*; #(
  parameter int unsigned BIN_W      = 7,
  parameter int unsigned COUNT_BITS = 10,
  parameter int unsigned CELL_ID    = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  logic                  prev_valid,
  input  cmd_t                  prev_cmd,
  input  logic [BIN_W-1:0]      prev_bin,
  input  logic [COUNT_BITS-1:0] prev_count,
  input  res_t                  prev_res,
  output logic                  next_valid,
  output cmd_t                  next_cmd,
  output logic [BIN_W-1:0]      next_bin,
  output logic [COUNT_BITS-1:0] next_count,
  output res_t                  next_res
);

  localparam logic [BIN_W-1:0]      MY_BIN    = BIN_W'(CELL_ID);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  valid_r;
  cmd_t                  cmd_r;
  logic [BIN_W-1:0]      bin_r;
  logic [COUNT_BITS-1:0] carry_r, carry_nxt;
  res_t                  res_r;
  logic                  hit;

  assign hit = prev_valid && (prev_bin == MY_BIN);

  always_comb begin
    count_nxt = count_r;
    carry_nxt = prev_count;
    if (hit && prev_cmd.inc && (count_r != COUNT_MAX)) begin
      count_nxt = count_r + 1'b1;
    end
    if (hit && prev_cmd.rd) begin
      carry_nxt = count_r;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else if (advance) begin
      count_r <= count_nxt;
      valid_r <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cmd_r   <= prev_cmd;
      bin_r   <= prev_bin;
      carry_r <= carry_nxt;
      res_r   <= prev_res;
    end
  end

  assign next_valid = valid_r;
  assign next_cmd   = cmd_r;
  assign next_bin   = bin_r;
  assign next_count = carry_r;
  assign next_res   = res_r;

endmodule

[rtl/pulse_period_histogram.sv]
// pulse period histogram
// in channel: one transaction per item, in_tuser holds the kind (capture edge,
// read and clear bin, start run), in_tdata the timestamp and the bin index.
// a capture measures the period to the previous edge of the armed run and bumps
// the bin of an in-window period; a read returns one bin count and clears it.
// out channel: exactly one result transaction per input transaction, in order.
// cfg port: lower_limit and period_target, written by the user only while the
// block is idle; the block does not enforce this. throughput is one item per
// cycle while the chain is not held. the front stage registers the item and
// updates the run state, then each bin cell of the chain registers it in turn,
// the last cell driving the output. each cell owns one bin counter and handles
// the transactions that pass it in order, so no forwarding between transactions
// is needed. with out_tready low and out_tvalid high all cells hold; the front
// stage still takes one more item while it is empty, then in_tready drops.
// reset clears the run state, all bin counters and the pipeline, and loads the
// register defaults (lower_limit 950, period_target 1000).
module pulse_period_histogram import pph_pkg::*; #(
  parameter int unsigned BIN_COUNT  = 101,
  parameter int unsigned COUNT_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [13:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] kind
  input  logic [1:0]  in_tuser,
  // [31:0] timestamp, [38:32] bin_index, [39] zero
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] period, [32] in_window, [42:33] bin_count, [43] run_done, [47:44] zero
  output logic [47:0] out_tdata
);

  localparam int unsigned BIN_W = $clog2(BIN_COUNT);

  logic                  advance;
  logic                  chain_valid [BIN_COUNT+1];
  cmd_t                  chain_cmd   [BIN_COUNT+1];
  logic [BIN_W-1:0]      chain_bin   [BIN_COUNT+1];
  logic [COUNT_BITS-1:0] chain_count [BIN_COUNT+1];
  res_t                  chain_res   [BIN_COUNT+1];
  logic [31:0]           count_ext;
  res_t                  out_res;
  cmd_t                  out_cmd;

  assign advance = out_tready || !chain_valid[BIN_COUNT];

  pph_front #(
    .BIN_COUNT (BIN_COUNT),
    .BIN_W     (BIN_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .advance   (advance),
    .in_ready  (in_tready),
    .kind      (in_tuser),
    .timestamp (in_tdata[31:0]),
    .bin_index (in_tdata[38:32]),
    .op_valid  (chain_valid[0]),
    .op_cmd    (chain_cmd[0]),
    .op_bin    (chain_bin[0]),
    .op_res    (chain_res[0])
  );

  assign chain_count[0] = '0;

  for (genvar i = 0; i < BIN_COUNT; i++) begin : g_cell
    pph_cell #(
      .BIN_W      (BIN_W),
      .COUNT_BITS (COUNT_BITS),
      .CELL_ID    (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .advance    (advance),
      .prev_valid (chain_valid[i]),
      .prev_cmd   (chain_cmd[i]),
      .prev_bin   (chain_bin[i]),
      .prev_count (chain_count[i]),
      .prev_res   (chain_res[i]),
      .next_valid (chain_valid[i+1]),
      .next_cmd   (chain_cmd[i+1]),
      .next_bin   (chain_bin[i+1]),
      .next_count (chain_count[i+1]),
      .next_res   (chain_res[i+1])
    );
  end

  assign out_res   = chain_res[BIN_COUNT];
  assign out_cmd   = chain_cmd[BIN_COUNT];
  assign count_ext = 32'(chain_count[BIN_COUNT]);

  assign out_tvalid = chain_valid[BIN_COUNT];
  assign out_tdata  = {4'd0, out_res.run_done, count_ext[OUT_COUNT_BITS-1:0],
                       out_res.in_window, out_res.period};

`ifndef SYNTHESIS
  // only a read picks up a count on its way through the cells
  a_count_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_cmd.rd |-> count_ext == 32'd0)
    else $error("bin count on a result that is not a read");

  // a bin is bumped only for a period inside the window
  a_inc_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_cmd.inc |-> out_res.in_window)
    else $error("bin increment without in_window");

  // a read carries no period
  a_read_no_period: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_cmd.rd |-> out_res.period == 32'd0 && !out_res.in_window)
    else $error("read result with a period");

  // the front never issues both operations for one transaction
  a_front_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    chain_valid[0] |-> !(chain_cmd[0].inc && chain_cmd[0].rd))
    else $error("increment and read in one transaction");
`endif

endmodule
